@@ hdl/serial_set_ascii_time_clock_unit_macros.svh @@
// Assertion macros shared by the serial time clock checker.
// Included by bare file name from hdl/sstc_checker.sv; no other dependencies.
`ifndef SERIAL_SET_ASCII_TIME_CLOCK_UNIT_MACROS_SVH
`define SERIAL_SET_ASCII_TIME_CLOCK_UNIT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, muted while reset is high.
`define SSTC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define SSTC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/sstc_pkg.sv @@
// Shared types, constants and digit helpers for the serial time clock.
// Used by sstc_advance and serial_set_ascii_time_clock_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sstc_pkg;

   typedef logic [7:0] char_type;
   // Eight characters, position 0 in the lowest byte.
   typedef char_type [7:0] time_str_type;

   // Kind of an input beat.
   typedef enum logic {
      REQ_BYTE = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   localparam char_type     SET_MARK     = 8'h25;
   localparam int unsigned  FRAME_LEN    = 8;
   localparam char_type     DIGIT_BASE   = 8'h30;
   localparam int unsigned  MIN_SEC_WRAP = 60;
   localparam int unsigned  HOUR_WRAP    = 24;
   localparam time_str_type TIME_RESET   = 64'h3030_3A30_303A_3030;

   // Value of an ASCII digit; anything else counts as zero.
   function automatic logic [3:0] digit_value(input char_type c);
      if (c >= DIGIT_BASE && c <= DIGIT_BASE + 8'd9) begin
         return c[3:0];
      end
      return 4'd0;
   endfunction

   // Two-digit field decoded and clamped to limit.
   function automatic logic [6:0] read_field(input char_type hi, input char_type lo,
                                             input logic [6:0] limit);
      logic [6:0] v;
      v = 7'(digit_value(hi)) * 7'd10 + 7'(digit_value(lo));
      return (v > limit) ? limit : v;
   endfunction

   // Two ASCII digits for a value below 60: tens in the low byte, units above.
   function automatic logic [15:0] write_field(input logic [5:0] v);
      logic [2:0] tens;
      logic [5:0] units;
      tens = 3'd0;
      for (int i = 1; i <= 5; i++) begin
         if (v >= 6'(i * 10)) begin
            tens = tens + 3'd1;
         end
      end
      units = v - 6'(tens) * 6'd10;
      return {DIGIT_BASE + {4'd0, units[3:0]}, DIGIT_BASE + {5'd0, tens}};
   endfunction

endpackage

`default_nettype wire

@@ hdl/serial_set_ascii_time_clock_unit.sv @@
// Serial-settable HH:MM:SS clock: input register, update logic, result register.
// Depends on sstc_pkg and sstc_advance.
//
// Usage:
//   The req channel carries one beat per event. req_tuser selects the kind:
//   0 is a received serial byte in req_tdata, 1 is a one-second tick.
//   A '%' byte opens or restarts a set frame; the next eight bytes overwrite the eight
//   string positions raw, after which ticking resumes. Ticks inside a frame
//   and other bytes outside a frame leave the time as it is.
//   Every accepted beat gives exactly one rsp beat carrying the full string
//   after the event, a refresh flag (tick advanced the time) and a busy flag
//   (set frame still open).
//   Each beat is held in the input register and then in the result register, which offers it.
//   Throughput: one beat per cycle while rsp_tready is high; the input register and the result
//   register each hold one beat, so a new request is taken while a finished
//   result waits. The single time string register sets the order of updates.
//   When rsp_tready is held low, both registers fill and req_tready drops;
//   nothing is lost or repeated.
//   Reset sets the string to "00:00:00", closes any frame and empties both
//   registers.
`timescale 1ns / 1ps
`default_nettype none

module serial_set_ascii_time_clock_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // char_0 [7:0] up to char_7 [63:56]
   output logic [1:0]  rsp_tuser    // [0] refresh, [1] set_busy
);

   // Input register.
   logic                      in_valid_ff, in_valid_in;
   sstc_pkg::req_kind_type    in_kind_ff;
   sstc_pkg::char_type        in_byte_ff;

   // Clock state.
   sstc_pkg::time_str_type    time_ff, time_in, tick_time;
   logic                      busy_ff, busy_in;
   logic [2:0]                pos_ff, pos_in;
   logic                      refresh;

   // Result register.
   logic                      out_valid_ff, out_valid_in;
   sstc_pkg::time_str_type    out_data_ff;
   logic [1:0]                out_user_ff;

   logic                      stage_go;
   logic                      req_take;

   // A held beat moves on when the result register is free or being drained.
   assign stage_go   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || stage_go;
   assign req_take   = req_tvalid && req_tready;

   sstc_advance u_advance (
      .cur_time  (time_ff),
      .next_time (tick_time)
   );

   // Next clock state for the beat leaving the input register.
   always_comb begin
      time_in = time_ff;
      busy_in = busy_ff;
      pos_in  = pos_ff;
      refresh = 1'b0;
      if (stage_go) begin
         case (in_kind_ff)
            sstc_pkg::REQ_BYTE: begin
               if (in_byte_ff == sstc_pkg::SET_MARK) begin
                  busy_in = 1'b1;
                  pos_in  = 3'd0;
               end else if (busy_ff) begin
                  time_in[pos_ff] = in_byte_ff;
                  if (pos_ff == 3'(sstc_pkg::FRAME_LEN - 1)) begin
                     busy_in = 1'b0;
                     pos_in  = 3'd0;
                  end else begin
                     pos_in = pos_ff + 3'd1;
                  end
               end
            end
            sstc_pkg::REQ_TICK: begin
               if (!busy_ff) begin
                  time_in = tick_time;
                  refresh = 1'b1;
               end
            end
            default: begin
               time_in = time_ff;
            end
         endcase
      end
   end

   // Valid flags of the two registers.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (stage_go) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (stage_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and clock state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         time_ff      <= sstc_pkg::TIME_RESET;
         busy_ff      <= 1'b0;
         pos_ff       <= 3'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         time_ff      <= time_in;
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= sstc_pkg::req_kind_type'(req_tuser);
         in_byte_ff <= req_tdata;
      end
      if (stage_go) begin
         out_data_ff <= time_in;
         out_user_ff <= {busy_in, refresh};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

`default_nettype wire

@@ hdl/sstc_advance.sv @@
// One-second advance of an HH:MM:SS string, purely combinational.
// Depends on sstc_pkg for the string type and digit helpers.
`timescale 1ns / 1ps
`default_nettype none

module sstc_advance (
   input  sstc_pkg::time_str_type cur_time,
   output sstc_pkg::time_str_type next_time
);

   logic [6:0] hh_raw, mm_raw, ss_raw;
   logic [4:0] hh, hh_n;
   logic [5:0] mm, mm_n, ss, ss_n;
   logic       ss_wrap, mm_wrap;

   // Decode the three fields, clamped to their legal ranges.
   assign hh_raw = sstc_pkg::read_field(cur_time[0], cur_time[1],
                                        7'(sstc_pkg::HOUR_WRAP - 1));
   assign mm_raw = sstc_pkg::read_field(cur_time[3], cur_time[4],
                                        7'(sstc_pkg::MIN_SEC_WRAP - 1));
   assign ss_raw = sstc_pkg::read_field(cur_time[6], cur_time[7],
                                        7'(sstc_pkg::MIN_SEC_WRAP - 1));
   assign hh = hh_raw[4:0];
   assign mm = mm_raw[5:0];
   assign ss = ss_raw[5:0];

   // Seconds carry into minutes, minutes into hours.
   assign ss_wrap = (ss == 6'(sstc_pkg::MIN_SEC_WRAP - 1));
   assign mm_wrap = (mm == 6'(sstc_pkg::MIN_SEC_WRAP - 1));

   always_comb begin
      ss_n = ss_wrap ? 6'd0 : ss + 6'd1;
      mm_n = mm;
      hh_n = hh;
      if (ss_wrap) begin
         mm_n = mm_wrap ? 6'd0 : mm + 6'd1;
         if (mm_wrap) begin
            hh_n = (hh == 5'(sstc_pkg::HOUR_WRAP - 1)) ? 5'd0 : hh + 5'd1;
         end
      end
   end

   // Re-encode the digits; separators pass through untouched.
   always_comb begin
      next_time = cur_time;
      {next_time[1], next_time[0]} = sstc_pkg::write_field({1'b0, hh_n});
      {next_time[4], next_time[3]} = sstc_pkg::write_field(mm_n);
      {next_time[7], next_time[6]} = sstc_pkg::write_field(ss_n);
   end

endmodule

`default_nettype wire

@@ hdl/sstc_checker.sv @@
// Port-level checks for the serial time clock, bound to the top level.
// Depends on serial_set_ascii_time_clock_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_set_ascii_time_clock_unit_macros.svh"

module sstc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled result beat stays put.
   `SSTC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp beat changed while stalled")

   // A tick only advances the time outside a set frame.
   `SSTC_ASSERT(a_refresh_not_busy, clock, reset, rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]), "refresh reported during a set frame")

   // An advanced time holds legal tens digits.
   `SSTC_ASSERT(a_refresh_digits, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[7:0] >= 8'h30 && rsp_tdata[7:0] <= 8'h32 && rsp_tdata[31:24] >= 8'h30 && rsp_tdata[31:24] <= 8'h35 && rsp_tdata[55:48] >= 8'h30 && rsp_tdata[55:48] <= 8'h35, "tick produced an illegal digit")

   // Reset empties the result register.
   `SSTC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result beat offered right after reset")

   // With the result register empty, an offered request beat is always taken.
   `SSTC_ASSERT(a_ready_when_empty, clock, reset, req_tvalid && !rsp_tvalid |-> req_tready, "request stalled with an empty result register")

endmodule

bind serial_set_ascii_time_clock_unit sstc_checker u_sstc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ verif/time_clock_checker.sv @@
// Result checker for the serial time clock: follows each accepted request beat with
// its own model of the clock and compares every result beat with the oldest prediction.
// Depends on sstc_pkg for the character types and constants.
`timescale 1ns / 1ps

module time_clock_checker
   import sstc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] req_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // char_0 [7:0] up to char_7 [63:56]
   input  logic [1:0]  rsp_tuser,   // [0] refresh, [1] set_busy
   output int          fail_count,
   output int          pending_count
);

   localparam int REPORT_LIMIT = 10;

   // What the block should show after one event.
   typedef struct {
      time_str_type text;
      logic         refresh;
      logic         busy;
   } clock_view_t;

   time_str_type clock_text;
   logic         frame_open;
   logic [2:0]   frame_pos;
   clock_view_t  awaited_views[$];

   // Numeric value of one character; anything that is not a digit reads as zero.
   function automatic int char_digit(input char_type c);
      return (c >= DIGIT_BASE && c <= DIGIT_BASE + 9) ? int'(c - DIGIT_BASE) : 0;
   endfunction

   function automatic char_type digit_char(input int d);
      return char_type'(DIGIT_BASE + d);
   endfunction

   // Two-character field, saturated at its largest legal value.
   function automatic int field_value(input char_type hi, input char_type lo, input int limit);
      int v;
      v = char_digit(hi) * 10 + char_digit(lo);
      return (v > limit) ? limit : v;
   endfunction

   // One second later; the separator positions pass through untouched.
   function automatic time_str_type tick_forward(input time_str_type t);
      int hh;
      int mm;
      int ss;
      time_str_type r;
      hh = field_value(t[0], t[1], HOUR_WRAP - 1);
      mm = field_value(t[3], t[4], MIN_SEC_WRAP - 1);
      ss = field_value(t[6], t[7], MIN_SEC_WRAP - 1);
      ss++;
      if (ss == MIN_SEC_WRAP) begin
         ss = 0;
         mm++;
         if (mm == MIN_SEC_WRAP) begin
            mm = 0;
            hh++;
            if (hh == HOUR_WRAP) begin
               hh = 0;
            end
         end
      end
      r = t;
      r[0] = digit_char(hh / 10);
      r[1] = digit_char(hh % 10);
      r[3] = digit_char(mm / 10);
      r[4] = digit_char(mm % 10);
      r[6] = digit_char(ss / 10);
      r[7] = digit_char(ss % 10);
      return r;
   endfunction

   // Update the clock model for one request beat and queue the view it leads to.
   task automatic apply_clock_event(input req_kind_type kind, input char_type rx);
      clock_view_t view;
      view.refresh = 1'b0;
      if (kind == REQ_BYTE) begin
         if (rx == SET_MARK) begin
            frame_open = 1'b1;
            frame_pos  = '0;
         end else if (frame_open) begin
            clock_text[frame_pos] = rx;
            if (frame_pos == FRAME_LEN - 1) begin
               frame_open = 1'b0;
               frame_pos  = '0;
            end else begin
               frame_pos++;
            end
         end
      end else if (!frame_open) begin
         clock_text   = tick_forward(clock_text);
         view.refresh = 1'b1;
      end
      view.text = clock_text;
      view.busy = frame_open;
      awaited_views.push_back(view);
   endtask

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Compare one result beat, field by field, with the oldest prediction.
   task automatic check_result(input time_str_type text, input logic refresh, input logic busy);
      clock_view_t want;
      int k;
      if (awaited_views.size() == 0) begin
         report_failure($sformatf("result beat with nothing expected: text %016h flags %b%b",
                                  text, busy, refresh));
         return;
      end
      want = awaited_views.pop_front();
      for (k = 0; k < 8; k++) begin
         if (text[k] !== want.text[k]) begin
            report_failure($sformatf("char_%0d mismatch: expected %02h, got %02h",
                                     k, want.text[k], text[k]));
         end
      end
      if (refresh !== want.refresh) begin
         report_failure($sformatf("refresh mismatch: expected %b, got %b",
                                  want.refresh, refresh));
      end
      if (busy !== want.busy) begin
         report_failure($sformatf("set_busy mismatch: expected %b, got %b", want.busy, busy));
      end
   endtask

   // Results are taken before requests, since a result never belongs to a request
   // accepted on the same edge.
   always @(posedge clock) begin
      if (reset) begin
         clock_text = TIME_RESET;
         frame_open = 1'b0;
         frame_pos  = '0;
         awaited_views.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
         end
         if (req_tvalid && req_tready) begin
            apply_clock_event(req_kind_type'(req_tuser), req_tdata);
         end
      end
      pending_count = awaited_views.size();
   end

endmodule

@@ verif/tb_serial_set_ascii_time_clock_unit.sv @@
// Testbench top for serial_set_ascii_time_clock_unit: drives set frames, ticks and noise
// with random sender gaps and receiver stalls, and gives the verdict.
// Depends on sstc_pkg, the block itself and time_clock_checker.
`timescale 1ns / 1ps

module tb_serial_set_ascii_time_clock_unit;
   import sstc_pkg::*;

   localparam char_type COLON       = ":";
   localparam int       ITEM_TARGET = 575;
   localparam int       HOLD_CYCLES = 60;

   // Styles of the result-side ready pattern.
   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_MOSTLY,
      READY_SPARSE
   } ready_style_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int mismatch_total;
   int results_pending;
   int burst_left;
   int items_offered;
   bit long_hold_due;

   serial_set_ascii_time_clock_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   time_clock_checker u_time_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (mismatch_total),
      .pending_count (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the handshakes hang.
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Result-side ready: changing styles, plus one long hold-off when requested.
   initial begin
      int hold_left;
      int style_left;
      ready_style_t style;
      rsp_tready = 1'b0;
      hold_left  = 0;
      style_left = 0;
      style      = READY_ALWAYS;
      forever begin
         @(negedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left     = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = ready_style_t'($urandom_range(0, 3));
               style_left = $urandom_range(10, 60);
            end
            style_left--;
            case (style)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
               READY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
               default:      rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Offer one beat in the current burst; a new burst starts after a random gap.
   // Called and returns at a falling edge.
   task automatic offer_beat(input req_kind_type kind, input char_type rx);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_offered++;
   endtask

   // Stop sending until every predicted result has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (results_pending != 0) @(negedge clock);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) offer_beat(REQ_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_frame(input time_str_type t);
      int k;
      offer_beat(REQ_BYTE, SET_MARK);
      for (k = 0; k < 8; k++) begin
         offer_beat(REQ_BYTE, t[k]);
      end
   endtask

   function automatic time_str_type make_time(input int hh, input int mm, input int ss);
      time_str_type t;
      t[0] = char_type'(DIGIT_BASE + hh / 10);
      t[1] = char_type'(DIGIT_BASE + hh % 10);
      t[2] = COLON;
      t[3] = char_type'(DIGIT_BASE + mm / 10);
      t[4] = char_type'(DIGIT_BASE + mm % 10);
      t[5] = COLON;
      t[6] = char_type'(DIGIT_BASE + ss / 10);
      t[7] = char_type'(DIGIT_BASE + ss % 10);
      return t;
   endfunction

   // Random time biased toward carries, now and then with one arbitrary character.
   function automatic time_str_type random_time();
      time_str_type t;
      t = make_time(($urandom_range(0, 2) == 0) ? 23 : $urandom_range(0, 23),
                    ($urandom_range(0, 1) == 0) ? 59 : $urandom_range(0, 59),
                    ($urandom_range(0, 1) == 0) ? $urandom_range(55, 59)
                                                : $urandom_range(0, 59));
      if ($urandom_range(0, 5) == 0) begin
         t[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));
      end
      return t;
   endfunction

   initial begin
      time_str_type odd_text;
      int pick;
      int k;
      bit hold_done;
      bit drain_done;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      burst_left    = 0;
      items_offered = 0;
      long_hold_due = 1'b0;
      hold_done     = 1'b0;
      drain_done    = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: first tick from reset, then the full wrap after 23:59:59.
      send_ticks(1);
      send_frame(make_time(23, 59, 59));
      send_ticks(1);
      // An all-ones byte outside a frame is ignored.
      offer_beat(REQ_BYTE, 8'hFF);
      // A tick inside a frame is ignored, and a second percent restarts the frame.
      offer_beat(REQ_BYTE, SET_MARK);
      offer_beat(REQ_BYTE, "1");
      send_ticks(1);
      // Hours 97, minutes with a non-digit, seconds 99, odd separators: all clamp.
      odd_text = {"9", "9", 8'h00, 8'hFF, "6", "A", "7", "9"};
      send_frame(odd_text);
      send_ticks(1);

      // Random part: mostly frames followed by tick runs, some noise and broken frames.
      while (items_offered < ITEM_TARGET) begin
         if (!hold_done && items_offered > 150) begin
            long_hold_due = 1'b1;
            hold_done     = 1'b1;
         end
         if (!drain_done && items_offered > 320) begin
            wait_for_results();
            drain_done = 1'b1;
         end
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            send_frame(random_time());
            send_ticks(($urandom_range(0, 3) == 0) ? $urandom_range(55, 70)
                                                   : $urandom_range(1, 8));
         end else if (pick < 7) begin
            send_ticks($urandom_range(1, 20));
         end else if (pick < 8) begin
            repeat ($urandom_range(1, 3)) begin
               offer_beat(req_kind_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
         end else begin
            offer_beat(REQ_BYTE, SET_MARK);
            for (k = $urandom_range(1, 7); k > 0; k--) begin
               offer_beat(REQ_BYTE, 8'($urandom_range(0, 255)));
            end
            send_ticks($urandom_range(0, 2));
         end
      end

      wait_for_results();
      repeat (20) @(negedge clock);
      if (mismatch_total == 0 && results_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/sstc_pkg.sv
hdl/sstc_advance.sv
hdl/serial_set_ascii_time_clock_unit.sv
hdl/sstc_checker.sv
verif/time_clock_checker.sv
verif/tb_serial_set_ascii_time_clock_unit.sv
